>>> src/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg: shared definitions for the RPN stack calculator
// Stack geometry, Q32.32 limits, operation codes, sequencer states and the
// request/response bundles between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_OUT_W = 8;
  localparam int unsigned DATA_W      = 64;

  // restoring divide: 64 integer bits plus 32 fraction bits of quotient
  localparam int unsigned DIV_STEPS = 96;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  // four 32x32 partial products plus a step to drain the product register
  localparam int unsigned MUL_STEPS = 5;

  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_SHOW    = 3'd5,
    OP_UNKNOWN = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_GET_B,
    S_POP_A,
    S_GET_A,
    S_EXEC,
    S_PUSH,
    S_RESULT
  } seq_state_e;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_ADDSUB,
    ALU_MUL,
    ALU_DIV,
    ALU_SAT,
    ALU_DONE
  } alu_state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

>>> src/rpn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_if: token and result channels of the RPN stack calculator
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface rpn_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [63:0] number_value;

  modport source (output valid, output mode, output number_value, input ready);
  modport sink   (input valid, input mode, input number_value, output ready);
endinterface

interface rpn_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] shown_value;
  logic               shown;
  logic               zero_divisor;
  logic               stack_empty;
  logic               stack_full;
  logic               unknown_command;
  logic [7:0]         depth_after;

  modport source (
    output valid, output shown_value, output shown, output zero_divisor,
    output stack_empty, output stack_full, output unknown_command,
    output depth_after, input ready
  );
  modport sink (
    input valid, input shown_value, input shown, input zero_divisor,
    input stack_empty, input stack_full, input unknown_command,
    input depth_after, output ready
  );
endinterface

>>> src/rpn_stack_calculator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit: reverse Polish evaluator on a Q32.32 stack
// Sequencer, operand stack memory and one shared arithmetic unit.
// ----------------------------------------------------------------------------
// One token in, one result out. The block takes a token only when the
// sequencer is idle and works it to the end before taking the next; once
// the result register is loaded the sequencer returns to idle before it
// takes the next token. The work is set by the stack memory (registered
// read, so each pop is a pop state and then a get state) and by the
// arithmetic unit: add/subtract is one pass plus a done state, multiply
// runs four 32x32 partial products through one multiplier plus a drain
// step, divide produces one of its 96 quotient bits per cycle; multiply
// and divide then take a saturation state and a done state. A finished
// result sits in an output register, so the next token is accepted while
// that result still waits for the sink; the sequencer only stalls when a
// second result is ready and the first has not been taken. The stack
// memory has no reset: its read data is only used below the entry count,
// which reset clears.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rpn_in_if.sink      in_i,
  rpn_out_if.source   out_o
);

  // sequencer state and per-token registers
  rpn_pkg::seq_state_e state_q, state_d;
  rpn_pkg::op_e        op_q, op_d;

  logic [rpn_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [rpn_pkg::DATA_W-1:0] num_q, num_d;
  logic [rpn_pkg::DATA_W-1:0] b_q, b_d;
  logic [rpn_pkg::DATA_W-1:0] shown_val_q, shown_val_d;
  logic                       hit_q, hit_d;        // last pop found an entry
  logic                       empty_q, empty_d;
  logic                       full_q, full_d;
  logic                       zdiv_q, zdiv_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [rpn_pkg::DATA_W-1:0]     o_val_q, o_val_d;
  logic                           o_shown_q, o_shown_d;
  logic                           o_zdiv_q, o_zdiv_d;
  logic                           o_empty_q, o_empty_d;
  logic                           o_full_q, o_full_d;
  logic                           o_unk_q, o_unk_d;
  logic [rpn_pkg::DEPTH_OUT_W-1:0] o_depth_q, o_depth_d;

  // memory and arithmetic unit hookup
  logic                       mem_we;
  logic [rpn_pkg::IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [rpn_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
  logic [rpn_pkg::CNT_W-1:0]  cnt_m1;
  logic [rpn_pkg::DATA_W-1:0] pop_val;
  rpn_pkg::alu_req_t          alu_req;
  rpn_pkg::alu_rsp_t          alu_rsp;
  logic [rpn_pkg::DATA_W-1:0] alu_res;

  logic                       in_fire, out_free, not_full;
  logic [rpn_pkg::CNT_W+rpn_pkg::DEPTH_OUT_W-1:0] cnt_ext;

  function automatic rpn_pkg::op_e decode_mode(logic [2:0] m);
    case (m)
      rpn_pkg::OP_PUSH: decode_mode = rpn_pkg::OP_PUSH;
      rpn_pkg::OP_ADD:  decode_mode = rpn_pkg::OP_ADD;
      rpn_pkg::OP_SUB:  decode_mode = rpn_pkg::OP_SUB;
      rpn_pkg::OP_MUL:  decode_mode = rpn_pkg::OP_MUL;
      rpn_pkg::OP_DIV:  decode_mode = rpn_pkg::OP_DIV;
      rpn_pkg::OP_SHOW: decode_mode = rpn_pkg::OP_SHOW;
      default:          decode_mode = rpn_pkg::OP_UNKNOWN; // mode seven too
    endcase
  endfunction

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign cnt_m1   = cnt_q - 1'b1;
  assign not_full = (cnt_q < rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
  // an empty pop reads as zero
  assign pop_val  = hit_q ? mem_rdata : '0;
  assign cnt_ext  = {{rpn_pkg::DEPTH_OUT_W{1'b0}}, cnt_q};

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpn_pkg::S_IDLE: begin
        if (in_fire) begin
          case (decode_mode(in_i.mode))
            rpn_pkg::OP_PUSH:    state_d = rpn_pkg::S_PUSH;
            rpn_pkg::OP_UNKNOWN: state_d = rpn_pkg::S_RESULT;
            default:             state_d = rpn_pkg::S_POP_B;
          endcase
        end
      end
      rpn_pkg::S_POP_B: state_d = rpn_pkg::S_GET_B;
      rpn_pkg::S_GET_B: begin
        // show ends here; a zero divisor leaves the dividend in place
        if (op_q == rpn_pkg::OP_SHOW) begin
          state_d = rpn_pkg::S_RESULT;
        end else if ((op_q == rpn_pkg::OP_DIV) && (pop_val == '0)) begin
          state_d = rpn_pkg::S_RESULT;
        end else begin
          state_d = rpn_pkg::S_POP_A;
        end
      end
      rpn_pkg::S_POP_A: state_d = rpn_pkg::S_GET_A;
      rpn_pkg::S_GET_A: state_d = rpn_pkg::S_EXEC;
      rpn_pkg::S_EXEC: begin
        if (alu_rsp.done) begin
          state_d = rpn_pkg::S_PUSH;
        end
      end
      rpn_pkg::S_PUSH:  state_d = rpn_pkg::S_RESULT;
      rpn_pkg::S_RESULT: begin
        if (out_free) begin
          state_d = rpn_pkg::S_IDLE;
        end
      end
      default: state_d = rpn_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------------ outputs
  always_comb begin
    in_i.ready    = (state_q == rpn_pkg::S_IDLE);
    mem_raddr     = cnt_m1[rpn_pkg::IDX_W-1:0];
    mem_we        = (state_q == rpn_pkg::S_PUSH) && not_full;
    mem_waddr     = cnt_q[rpn_pkg::IDX_W-1:0];
    mem_wdata     = num_q;
    alu_req.start = (state_q == rpn_pkg::S_GET_A);
    alu_req.op    = op_q;
  end

  // ----------------------------------------------------------------- datapath
  always_comb begin
    op_d        = op_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    b_d         = b_q;
    shown_val_d = shown_val_q;
    hit_d       = hit_q;
    empty_d     = empty_q;
    full_d      = full_q;
    zdiv_d      = zdiv_q;
    out_valid_d = out_valid_q && !out_o.ready;
    o_val_d     = o_val_q;
    o_shown_d   = o_shown_q;
    o_zdiv_d    = o_zdiv_q;
    o_empty_d   = o_empty_q;
    o_full_d    = o_full_q;
    o_unk_d     = o_unk_q;
    o_depth_d   = o_depth_q;

    case (state_q)
      rpn_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d        = decode_mode(in_i.mode);
          num_d       = in_i.number_value;
          shown_val_d = '0;
          empty_d     = 1'b0;
          full_d      = 1'b0;
          zdiv_d      = 1'b0;
        end
      end
      rpn_pkg::S_POP_B, rpn_pkg::S_POP_A: begin
        hit_d = (cnt_q != '0);
        if (cnt_q != '0) begin
          cnt_d = cnt_m1;
        end else begin
          empty_d = 1'b1;
        end
      end
      rpn_pkg::S_GET_B: begin
        b_d = pop_val;
        if (op_q == rpn_pkg::OP_SHOW) begin
          shown_val_d = pop_val;
        end else if ((op_q == rpn_pkg::OP_DIV) && (pop_val == '0)) begin
          zdiv_d = 1'b1;
        end
      end
      rpn_pkg::S_EXEC: begin
        if (alu_rsp.done) begin
          num_d = alu_res;
        end
      end
      rpn_pkg::S_PUSH: begin
        if (not_full) begin
          cnt_d = cnt_q + 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
      rpn_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_val_d     = shown_val_q;
          o_shown_d   = (op_q == rpn_pkg::OP_SHOW);
          o_zdiv_d    = zdiv_q;
          o_empty_d   = empty_q;
          o_full_d    = full_q;
          o_unk_d     = (op_q == rpn_pkg::OP_UNKNOWN);
          o_depth_d   = cnt_ext[rpn_pkg::DEPTH_OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpn_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    num_q       <= num_d;
    b_q         <= b_d;
    shown_val_q <= shown_val_d;
    hit_q       <= hit_d;
    empty_q     <= empty_d;
    full_q      <= full_d;
    zdiv_q      <= zdiv_d;
    o_val_q     <= o_val_d;
    o_shown_q   <= o_shown_d;
    o_zdiv_q    <= o_zdiv_d;
    o_empty_q   <= o_empty_d;
    o_full_q    <= o_full_d;
    o_unk_q     <= o_unk_d;
    o_depth_q   <= o_depth_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.shown_value     = o_val_q;
  assign out_o.shown           = o_shown_q;
  assign out_o.zero_divisor    = o_zdiv_q;
  assign out_o.stack_empty     = o_empty_q;
  assign out_o.stack_full      = o_full_q;
  assign out_o.unknown_command = o_unk_q;
  assign out_o.depth_after     = o_depth_q;

  // ------------------------------------------------------------ submodules
  rpn_stack_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // left operand comes straight off the memory read; right one was held
  rpn_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (pop_val),
    .b_i      (b_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

endmodule

>>> src/rpn_stack_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_mem: operand stack storage
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module rpn_stack_mem (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [rpn_pkg::IDX_W-1:0]        waddr_i,
  input  logic [rpn_pkg::DATA_W-1:0]       wdata_i,
  input  logic [rpn_pkg::IDX_W-1:0]        raddr_i,
  output logic [rpn_pkg::DATA_W-1:0]       rdata_o
);

  logic [rpn_pkg::DATA_W-1:0] mem_q [rpn_pkg::STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/rpn_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_alu: shared Q32.32 arithmetic unit
// Saturating add/sub in one pass, multiply from four 32x32 partial products,
// divide one quotient bit per cycle (restoring), saturation stage shared by mul/div.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rpn_pkg::alu_req_t          req_i,
  input  logic [rpn_pkg::DATA_W-1:0] a_i,
  input  logic [rpn_pkg::DATA_W-1:0] b_i,
  output rpn_pkg::alu_rsp_t          rsp_o,
  output logic [rpn_pkg::DATA_W-1:0] result_o
);

  rpn_pkg::alu_state_e state_q, state_d;
  rpn_pkg::op_e        op_q, op_d;

  logic [63:0]               a_q, a_d, b_q, b_d;
  logic [63:0]               x_q, x_d, y_q, y_d;
  logic                      neg_q, neg_d;
  logic [63:0]               r_q, r_d, quo_q, quo_d;
  logic                      ovf_q, ovf_d;
  logic [127:0]              acc_q, acc_d;
  logic [63:0]               pp_q, pp_d;
  logic [1:0]                sh_q, sh_d;
  logic [rpn_pkg::STEP_W-1:0] step_q, step_d;
  logic [63:0]               res_q, res_d;

  // combinational helpers
  logic [63:0]  sum, dif;
  logic [31:0]  mx, my;
  logic [127:0] pp_shifted;
  logic [64:0]  r_shift, r_trial;
  logic         r_ge;
  logic [63:0]  sat_m;
  logic         sat_ovf;

  function automatic logic [63:0] magnitude(logic [63:0] v);
    magnitude = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] signed_sat(logic [63:0] m, logic neg, logic ovf);
    if (neg) begin
      signed_sat = (ovf || (m > rpn_pkg::Q_MIN)) ? rpn_pkg::Q_MIN : (64'd0 - m);
    end else begin
      signed_sat = (ovf || m[63]) ? rpn_pkg::Q_MAX : m;
    end
  endfunction

  // datapath pieces
  always_comb begin
    sum = a_q + b_q;
    dif = a_q - b_q;

    // step order: xl*yl, xl*yh, xh*yl, xh*yh
    mx = step_q[1] ? x_q[63:32] : x_q[31:0];
    my = step_q[0] ? y_q[63:32] : y_q[31:0];

    case (sh_q)
      2'd0:    pp_shifted = {64'd0, pp_q};
      2'd1:    pp_shifted = {32'd0, pp_q, 32'd0};
      default: pp_shifted = {pp_q, 64'd0};
    endcase

    r_shift = {r_q, x_q[63]};
    r_ge    = (r_shift >= {1'b0, y_q});
    r_trial = r_shift - {1'b0, y_q};

    if (op_q == rpn_pkg::OP_MUL) begin
      sat_m   = acc_q[95:32];
      sat_ovf = |acc_q[127:96];
    end else begin
      sat_m   = quo_q;
      sat_ovf = ovf_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpn_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            rpn_pkg::OP_MUL: state_d = rpn_pkg::ALU_MUL;
            rpn_pkg::OP_DIV: state_d = rpn_pkg::ALU_DIV;
            default:         state_d = rpn_pkg::ALU_ADDSUB;
          endcase
        end
      end
      rpn_pkg::ALU_ADDSUB: state_d = rpn_pkg::ALU_DONE;
      rpn_pkg::ALU_MUL: begin
        if (step_q == rpn_pkg::STEP_W'(rpn_pkg::MUL_STEPS - 1)) begin
          state_d = rpn_pkg::ALU_SAT;
        end
      end
      rpn_pkg::ALU_DIV: begin
        if (step_q == rpn_pkg::STEP_W'(rpn_pkg::DIV_STEPS - 1)) begin
          state_d = rpn_pkg::ALU_SAT;
        end
      end
      rpn_pkg::ALU_SAT:  state_d = rpn_pkg::ALU_DONE;
      rpn_pkg::ALU_DONE: state_d = rpn_pkg::ALU_IDLE;
      default:           state_d = rpn_pkg::ALU_IDLE;
    endcase
  end

  // register updates
  always_comb begin
    op_d   = op_q;
    a_d    = a_q;
    b_d    = b_q;
    x_d    = x_q;
    y_d    = y_q;
    neg_d  = neg_q;
    r_d    = r_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    acc_d  = acc_q;
    pp_d   = pp_q;
    sh_d   = sh_q;
    step_d = step_q;
    res_d  = res_q;
    case (state_q)
      rpn_pkg::ALU_IDLE: begin
        if (req_i.start) begin
          op_d   = req_i.op;
          a_d    = a_i;
          b_d    = b_i;
          x_d    = magnitude(a_i);
          y_d    = magnitude(b_i);
          neg_d  = a_i[63] ^ b_i[63];
          r_d    = '0;
          quo_d  = '0;
          ovf_d  = 1'b0;
          acc_d  = '0;
          step_d = '0;
        end
      end
      rpn_pkg::ALU_ADDSUB: begin
        if (op_q == rpn_pkg::OP_SUB) begin
          if ((a_q[63] != b_q[63]) && (dif[63] != a_q[63])) begin
            res_d = a_q[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
          end else begin
            res_d = dif;
          end
        end else begin
          if ((a_q[63] == b_q[63]) && (sum[63] != a_q[63])) begin
            res_d = a_q[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
          end else begin
            res_d = sum;
          end
        end
      end
      rpn_pkg::ALU_MUL: begin
        // product registered, accumulated on the next step
        pp_d   = {32'd0, mx} * {32'd0, my};
        sh_d   = {1'b0, step_q[1]} + {1'b0, step_q[0]};
        if (step_q != '0) begin
          acc_d = acc_q + pp_shifted;
        end
        step_d = step_q + 1'b1;
      end
      rpn_pkg::ALU_DIV: begin
        r_d    = r_ge ? r_trial[63:0] : r_shift[63:0];
        ovf_d  = ovf_q | quo_q[63];
        quo_d  = {quo_q[62:0], r_ge};
        x_d    = {x_q[62:0], 1'b0};
        step_d = step_q + 1'b1;
      end
      rpn_pkg::ALU_SAT: begin
        res_d = signed_sat(sat_m, neg_q, sat_ovf);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpn_pkg::ALU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    y_q    <= y_d;
    neg_q  <= neg_d;
    r_q    <= r_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    acc_q  <= acc_d;
    pp_q   <= pp_d;
    sh_q   <= sh_d;
    step_q <= step_d;
    res_q  <= res_d;
  end

  // outputs
  always_comb begin
    rsp_o.done = (state_q == rpn_pkg::ALU_DONE);
    rsp_o.busy = (state_q != rpn_pkg::ALU_IDLE);
    result_o   = res_q;
  end

endmodule

>>> sim/rpn_stack_calculator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit_test: self-checking bench for the RPN calculator
// Drives tokens over the valid/ready token channel. Each accepted token is
// run through a Q32.32 stack calculator model kept in the bench, and the
// model's result, or a typed row's own result, is queued. Every result
// taken from the block is compared field by field with the oldest queued
// result. A short directed table covers the extremes and the error cases.
// Random token sequences follow under four idling patterns, and one fill
// of the stack runs against a long receiver hold-off.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_test;

  // Reserved mode encoding. The block handles it as an unknown command.
  localparam logic [2:0]  MODE_RESERVED = 3'd7;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned HOLD_CYCLES  = 400;     // receiver hold-off for the fill
  localparam int unsigned PHASE_ITEMS  = 225;     // random tokens per idling phase
  localparam int unsigned DRAIN_CYCLES = 150;     // longer than a divide
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned MAX_REPORTS  = 20;

  // One result item as the block presents it. Field order matters for outcome().
  typedef struct packed {
    logic [63:0] shown_value;
    logic        shown;
    logic        zero_divisor;
    logic        stack_empty;
    logic        stack_full;
    logic        unknown_command;
    logic [7:0]  depth_after;
  } calc_result_t;

  // One row of the directed table. When typed is set, want holds the result
  // as read off the spec. Otherwise the result comes from the stack model.
  typedef struct {
    logic [2:0]   mode;
    logic [63:0]  value;
    bit           typed;
    calc_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rpn_in_if  token_ch ();
  rpn_out_if result_ch ();

  rpn_stack_calculator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (token_ch),
    .out_o  (result_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stack calculator model: own copy of the operand stack and entry count
  // --------------------------------------------------------------------------
  logic [63:0]  calc_stack [rpn_pkg::STACK_DEPTH];
  int unsigned  calc_depth = 0;
  int unsigned  peak_depth = 0;

  calc_result_t expected_results [$];

  // coverage counters for the summary
  int unsigned  mode_seen [8];
  int unsigned  full_seen = 0;
  int unsigned  empty_seen = 0;
  int unsigned  zdiv_seen = 0;
  int unsigned  results_checked = 0;
  int unsigned  mismatches = 0;

  function automatic void calc_push(input logic [63:0] value, inout logic full_flag);
    if (calc_depth < rpn_pkg::STACK_DEPTH) begin
      calc_stack[calc_depth] = value;
      calc_depth++;
      if (calc_depth > peak_depth) peak_depth = calc_depth;
    end else begin
      full_flag = 1'b1;                      // dropped
    end
  endfunction

  // An empty pop yields zero and marks the step. The step goes on.
  function automatic logic [63:0] calc_pop(inout logic empty_flag);
    if (calc_depth == 0) begin
      empty_flag = 1'b1;
      return '0;
    end
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  // Give a magnitude its sign and clamp to the Q32.32 range.
  function automatic logic [63:0] fix_sign(logic [63:0] mag, logic neg, logic ovf);
    if (neg) return (ovf || mag > rpn_pkg::Q_MIN) ? rpn_pkg::Q_MIN : -mag;
    return (ovf || mag > rpn_pkg::Q_MAX) ? rpn_pkg::Q_MAX : mag;
  endfunction

  function automatic logic [63:0] fix_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
    return s;
  endfunction

  function automatic logic [63:0] fix_sub(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) return a[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
    return d;
  endfunction

  // Full 128-bit product of the magnitudes. Keep bits 95:32, and anything
  // above bit 95 means overflow.
  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0]  x, y;
    logic [127:0] prod;
    x = a[63] ? -a : a;
    y = b[63] ? -b : b;
    prod = {64'b0, x} * {64'b0, y};
    return fix_sign(prod[95:32], a[63] ^ b[63], prod[127:96] != '0);
  endfunction

  // (|a| * 2^32) / |b|, truncated. A quotient wider than 64 bits saturates.
  function automatic logic [63:0] fix_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] x, y;
    logic [95:0] quo;
    x = a[63] ? -a : a;
    y = b[63] ? -b : b;
    quo = {x, 32'b0} / {32'b0, y};
    return fix_sign(quo[63:0], a[63] ^ b[63], quo[95:64] != '0);
  endfunction

  function automatic calc_result_t calc_step(logic [2:0] mode, logic [63:0] value);
    calc_result_t res;
    logic [63:0]  lhs, rhs;
    res = '0;
    case (mode)
      rpn_pkg::OP_PUSH: calc_push(value, res.stack_full);
      rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
        rhs = calc_pop(res.stack_empty);       // top entry is the right operand
        lhs = calc_pop(res.stack_empty);
        case (mode)
          rpn_pkg::OP_ADD: calc_push(fix_add(lhs, rhs), res.stack_full);
          rpn_pkg::OP_SUB: calc_push(fix_sub(lhs, rhs), res.stack_full);
          default:         calc_push(fix_mul(lhs, rhs), res.stack_full);
        endcase
      end
      rpn_pkg::OP_DIV: begin
        rhs = calc_pop(res.stack_empty);
        if (rhs != '0) begin
          lhs = calc_pop(res.stack_empty);
          calc_push(fix_div(lhs, rhs), res.stack_full);
        end else begin
          res.zero_divisor = 1'b1;             // divisor gone, dividend stays
        end
      end
      rpn_pkg::OP_SHOW: begin
        res.shown_value = calc_pop(res.stack_empty);
        res.shown       = 1'b1;
      end
      default: res.unknown_command = 1'b1;   // unknown command and the reserved code
    endcase
    res.depth_after = calc_depth[7:0];
    return res;
  endfunction

  function automatic calc_result_t outcome(logic [63:0] v, bit sh, bit zd, bit em,
                                           bit fu, bit un, logic [7:0] dep);
    return calc_result_t'({v, sh, zd, em, fu, un, dep});
  endfunction

  // --------------------------------------------------------------------------
  // Random tokens
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_fixed();
    logic [63:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = rpn_pkg::Q_MAX;
      2:       v = rpn_pkg::Q_MIN;
      3, 4:    v = {$urandom, $urandom};
      5:       v = 64'($urandom_range(255));                // a few LSBs only
      default: v = {32'($urandom_range(0, 1 << $urandom_range(0, 20))), $urandom};
    endcase
    if (v != rpn_pkg::Q_MAX && v != rpn_pkg::Q_MIN && $urandom_range(1)) v = -v;
    return v;
  endfunction

  // Most tokens form well-formed expressions. The stack is kept short, with
  // pushes when it holds under two entries and operators once it is deep.
  // A few percent are noise of any mode at any depth, which covers empty
  // pops, unknown and reserved codes.
  function automatic void pick_token(output logic [2:0] mode, output logic [63:0] value);
    int unsigned roll;
    roll  = $urandom_range(99);
    value = rand_fixed();
    if (roll < 8) begin
      mode = 3'($urandom_range(7));
    end else if (calc_depth < 2 || (calc_depth < 12 && roll < 52)) begin
      mode = rpn_pkg::OP_PUSH;
    end else begin
      case ($urandom_range(4))
        0:       mode = rpn_pkg::OP_ADD;
        1:       mode = rpn_pkg::OP_SUB;
        2:       mode = rpn_pkg::OP_MUL;
        3:       mode = rpn_pkg::OP_DIV;
        default: mode = rpn_pkg::OP_SHOW;
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Token driver
  // --------------------------------------------------------------------------
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;

  // Offer one token and wait for it to be taken. The model runs at the
  // accepting edge. An idle gap lowers valid at one edge and raises it at a
  // later one. Back-to-back tokens keep valid high.
  task automatic send_token(input logic [2:0] mode, input logic [63:0] value,
                            input bit typed, input calc_result_t want);
    calc_result_t predicted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      token_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    token_ch.valid        <= 1'b1;
    token_ch.mode         <= mode;
    token_ch.number_value <= value;
    do @(posedge clk_i); while (!token_ch.ready);
    predicted = calc_step(mode, value);
    expected_results.push_back(typed ? want : predicted);
    mode_seen[mode]++;
    full_seen  += predicted.stack_full;
    empty_seen += predicted.stack_empty;
    zdiv_seen  += predicted.zero_divisor;
  endtask

  // --------------------------------------------------------------------------
  // Result receiver. Stalls are random at the phase's stall rate. A hold-off
  // request drops ready and counts down from HOLD_CYCLES here, while the
  // token side keeps offering tokens.
  // --------------------------------------------------------------------------
  int unsigned hold_taken = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk_i) begin
    if (hold_taken != hold_req) begin
      hold_taken      <= hold_req;
      hold_left       <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                results_checked, field, got, want));
  endtask

  always @(posedge clk_i) begin
    calc_result_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with no token outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("shown_value",     result_ch.shown_value,     want.shown_value);
        check_field("shown",           result_ch.shown,           want.shown);
        check_field("zero_divisor",    result_ch.zero_divisor,    want.zero_divisor);
        check_field("stack_empty",     result_ch.stack_empty,     want.stack_empty);
        check_field("stack_full",      result_ch.stack_full,      want.stack_full);
        check_field("unknown_command", result_ch.unknown_command, want.unknown_command);
        check_field("depth_after",     result_ch.depth_after,     want.depth_after);
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_results.size());
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  int unsigned phase_send_idle  [4] = '{0, 66, 0, 7};
  int unsigned phase_recv_stall [4] = '{0, 0, 66, 7};

  initial begin
    stim_row_t   dir_rows [$];
    logic [2:0]  mode;
    logic [63:0] value;

    token_ch.valid        = 1'b0;
    token_ch.mode         = rpn_pkg::OP_PUSH;
    token_ch.number_value = '0;
    result_ch.ready       = 1'b0;
    rst_ni                = 1'b0;

    // Directed table. A bracketed list on a row's comment gives the stack after it.
    // Typed rows are the ones whose result is plain from the spec.
    // Show on an empty stack pops zero.                            []
    dir_rows.push_back('{rpn_pkg::OP_SHOW, '0, 1'b1, outcome('0, 1, 0, 1, 0, 0, 0)});
    // Add on an empty stack pushes 0 + 0.                          [0]
    dir_rows.push_back('{rpn_pkg::OP_ADD, '0, 1'b1, outcome('0, 0, 0, 1, 0, 0, 1)});
    dir_rows.push_back('{rpn_pkg::OP_PUSH, rpn_pkg::Q_MAX, 1'b1,
                         outcome('0, 0, 0, 0, 0, 0, 2)});
    dir_rows.push_back('{rpn_pkg::OP_PUSH, 64'd1, 1'b0, '0});
    dir_rows.push_back('{rpn_pkg::OP_ADD, '0, 1'b0, '0});          // saturates high
    dir_rows.push_back('{rpn_pkg::OP_SHOW, '0, 1'b1,
                         outcome(rpn_pkg::Q_MAX, 1, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN, 1'b0, '0});
    dir_rows.push_back('{rpn_pkg::OP_PUSH, 64'd1, 1'b0, '0});
    dir_rows.push_back('{rpn_pkg::OP_SUB, '0, 1'b0, '0});          // saturates low
    dir_rows.push_back('{rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN, 1'b0, '0});
    dir_rows.push_back('{rpn_pkg::OP_MUL, '0, 1'b0, '0});          // min * min
    dir_rows.push_back('{rpn_pkg::OP_SHOW, '0, 1'b1,
                         outcome(rpn_pkg::Q_MAX, 1, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{rpn_pkg::OP_PUSH, 64'h0000_0005_0000_0000, 1'b0, '0});  // 5.0
    dir_rows.push_back('{rpn_pkg::OP_PUSH, '0, 1'b0, '0});
    // Zero divisor: the divisor is dropped and 5.0 stays.          [0 5]
    dir_rows.push_back('{rpn_pkg::OP_DIV, '0, 1'b1, outcome('0, 0, 1, 0, 0, 0, 2)});
    dir_rows.push_back('{rpn_pkg::OP_PUSH, 64'hFFFF_FFFE_0000_0000, 1'b0, '0});  // -2.0
    dir_rows.push_back('{rpn_pkg::OP_DIV, '0, 1'b0, '0});          // -2.5
    dir_rows.push_back('{rpn_pkg::OP_SHOW, '0, 1'b0, '0});
    // min / (-2^-32) overflows the quotient and clamps high.
    dir_rows.push_back('{rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN, 1'b0, '0});
    dir_rows.push_back('{rpn_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0});
    dir_rows.push_back('{rpn_pkg::OP_DIV, '0, 1'b0, '0});
    dir_rows.push_back('{rpn_pkg::OP_SHOW, '0, 1'b1,
                         outcome(rpn_pkg::Q_MAX, 1, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{rpn_pkg::OP_UNKNOWN, '1, 1'b1, outcome('0, 0, 0, 0, 0, 1, 1)});
    dir_rows.push_back('{MODE_RESERVED, '1, 1'b1, outcome('0, 0, 0, 0, 0, 1, 1)});
    dir_rows.push_back('{rpn_pkg::OP_SHOW, '0, 1'b1, outcome('0, 1, 0, 0, 0, 0, 0)});
    // Divide on an empty stack: the divisor pops as zero.          []
    dir_rows.push_back('{rpn_pkg::OP_DIV, '0, 1'b1, outcome('0, 0, 1, 1, 0, 0, 0)});

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_token(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send_idle[p];
      recv_stall_pct = phase_recv_stall[p];
      if (p == 0) begin
        // Fill the stack past its top while the receiver holds off. The
        // output register fills, the sequencer stalls, and the token
        // channel backs up. The last pushes are dropped as full.
        hold_req <= hold_req + 1;
        repeat (rpn_pkg::STACK_DEPTH - calc_depth + 3)
          send_token(rpn_pkg::OP_PUSH, rand_fixed(), 1'b0, '0);
      end
      repeat (PHASE_ITEMS) begin
        pick_token(mode, value);
        send_token(mode, value, 1'b0, '0);
      end
    end

    token_ch.valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tokens: push %0d add %0d sub %0d mul %0d div %0d show %0d unknown %0d",
             mode_seen[rpn_pkg::OP_PUSH], mode_seen[rpn_pkg::OP_ADD],
             mode_seen[rpn_pkg::OP_SUB], mode_seen[rpn_pkg::OP_MUL],
             mode_seen[rpn_pkg::OP_DIV], mode_seen[rpn_pkg::OP_SHOW],
             mode_seen[rpn_pkg::OP_UNKNOWN] + mode_seen[MODE_RESERVED]);
    $display("%0d results checked, peak depth %0d; flagged full %0d, empty %0d, %s%0d",
             results_checked, peak_depth, full_seen, empty_seen,
             "zero divisor ", zdiv_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
